>>> rtl/lpcd_pkg.sv
// Shared types and constants for the length-prefixed chunk deframer.
// Depends on nothing; the files that use it refer to it by scoped names.
package lpcd_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_LENGTH  = 2'd1,
        MODE_PAYLOAD = 2'd2
    } parse_mode_t;

    localparam logic [7:0] CH_END   = 8'h24;  // '$'
    localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
    localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    typedef struct packed {
        logic       length_overflow;
        logic       message_end;
        logic       data_valid;
        logic [7:0] data_byte;
    } result_t;

endpackage

>>> rtl/lpcd_in_stage.sv
// Input register stage of the deframer: holds one received byte beat.
// Depends on nothing outside this file.
module lpcd_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       held_valid,
    input  logic       take,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The stage refills in the same cycle that its beat moves on.
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

>>> rtl/lpcd_parse.sv
// Framing state machine and length datapath of the deframer.
// Depends on lpcd_pkg for the mode type, framing characters and result struct.
module lpcd_parse #(
    parameter int LEN_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [7:0]         rx_byte,
    output lpcd_pkg::result_t  result
);

    localparam int WIDE_W = LEN_WIDTH + 4;

    lpcd_pkg::parse_mode_t mode_reg;
    lpcd_pkg::parse_mode_t mode_next;
    logic [LEN_WIDTH-1:0]  length_reg;
    logic [LEN_WIDTH-1:0]  length_next;
    logic                  stopped_reg;
    logic                  stopped_next;
    logic [LEN_WIDTH-1:0]  remaining_reg;
    logic [LEN_WIDTH-1:0]  remaining_next;

    logic                  is_digit;
    logic [WIDE_W-1:0]     length_wide;
    logic                  saturate;
    logic [LEN_WIDTH-1:0]  length_step;
    logic [LEN_WIDTH-1:0]  remaining_dec;

    assign is_digit = (rx_byte >= lpcd_pkg::CH_ZERO) && (rx_byte <= lpcd_pkg::CH_NINE);

    // length * 10 + digit, formed as (length << 3) + (length << 1) + digit.
    assign length_wide = {1'b0, length_reg, 3'b000} + {3'b000, length_reg, 1'b0}
                       + {{(WIDE_W-4){1'b0}}, rx_byte[3:0]};
    assign saturate    = |length_wide[WIDE_W-1:LEN_WIDTH];
    assign length_step = saturate ? {LEN_WIDTH{1'b1}} : length_wide[LEN_WIDTH-1:0];

    assign remaining_dec = remaining_reg - {{(LEN_WIDTH-1){1'b0}}, 1'b1};

    // Next mode.
    always_comb begin
        mode_next = lpcd_pkg::MODE_IDLE;
        unique case (mode_reg)
            lpcd_pkg::MODE_PAYLOAD: begin
                mode_next = (remaining_dec == '0) ? lpcd_pkg::MODE_IDLE
                                                  : lpcd_pkg::MODE_PAYLOAD;
            end
            lpcd_pkg::MODE_LENGTH: begin
                if (rx_byte == lpcd_pkg::CH_CLOSE) begin
                    mode_next = (length_reg != '0) ? lpcd_pkg::MODE_PAYLOAD
                                                   : lpcd_pkg::MODE_IDLE;
                end else begin
                    mode_next = lpcd_pkg::MODE_LENGTH;
                end
            end
            default: begin
                mode_next = (rx_byte == lpcd_pkg::CH_OPEN) ? lpcd_pkg::MODE_LENGTH
                                                           : lpcd_pkg::MODE_IDLE;
            end
        endcase
    end

    // Result fields and datapath updates.
    always_comb begin
        result         = '0;
        length_next    = length_reg;
        stopped_next   = stopped_reg;
        remaining_next = remaining_reg;
        unique case (mode_reg)
            lpcd_pkg::MODE_PAYLOAD: begin
                result.data_byte  = rx_byte;
                result.data_valid = 1'b1;
                remaining_next    = remaining_dec;
            end
            lpcd_pkg::MODE_LENGTH: begin
                if (rx_byte == lpcd_pkg::CH_CLOSE) begin
                    remaining_next = length_reg;
                    length_next    = '0;
                    stopped_next   = 1'b0;
                end else if (is_digit && !stopped_reg) begin
                    length_next            = length_step;
                    result.length_overflow = saturate;
                end else begin
                    stopped_next = 1'b1;
                end
            end
            default: begin
                if (rx_byte == lpcd_pkg::CH_END) begin
                    result.message_end = 1'b1;
                end else if (rx_byte == lpcd_pkg::CH_OPEN) begin
                    length_next  = '0;
                    stopped_next = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= lpcd_pkg::MODE_IDLE;
            length_reg    <= '0;
            stopped_reg   <= 1'b0;
            remaining_reg <= '0;
        end else if (advance) begin
            mode_reg      <= mode_next;
            length_reg    <= length_next;
            stopped_reg   <= stopped_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

>>> rtl/lpcd_out_stage.sv
// Result register stage of the deframer: holds one result beat for the sink.
// Depends on lpcd_pkg for the result struct.
module lpcd_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load_valid,
    output logic               load_ready,
    input  lpcd_pkg::result_t  load_result,
    output logic               out_valid,
    input  logic               out_ready,
    output lpcd_pkg::result_t  out_result
);

    logic              valid_reg;
    logic              valid_next;
    lpcd_pkg::result_t result_reg;

    assign load_ready = !valid_reg || out_ready;
    assign valid_next = (load_valid && load_ready) || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

>>> rtl/length_prefixed_chunk_deframer_top.sv
// Top level of the length-prefixed chunk deframer: input stage, parser, result stage.
// Depends on lpcd_pkg, lpcd_in_stage, lpcd_parse and lpcd_out_stage.
//
//  Channel   | Direction | tdata                | tuser
//  ----------+-----------+----------------------+-------------------------------------------
//  s_axis    | in        | [7:0] rx_byte        | none
//  m_axis    | out       | [7:0] data_byte      | [0] data_valid [1] message_end [2] length_overflow
//
// Every received byte gives exactly one result beat. The block takes one byte per cycle
// sustained while m_axis is ready; a byte's result passes from the input register through
// the combinational parser into the result register, which presents it on m_axis.
// Reset (aresetn low at a clock edge) empties both stages and returns the parser to idle
// between chunks with a zero length and payload count.
// When m_axis stalls, the result register holds its beat and the input register still
// takes one more byte; s_axis_tready falls only once both are full.
module length_prefixed_chunk_deframer_top #(
    parameter int LEN_WIDTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [2:0] m_axis_tuser    // [0] data_valid, [1] message_end, [2] length_overflow
);

    logic              held_valid;
    logic [7:0]        held_byte;
    logic              load_ready;
    logic              advance;
    lpcd_pkg::result_t parse_result;
    lpcd_pkg::result_t out_result;

    // A byte moves from the input register into the result register, and updates the
    // framing state, in the same cycle.
    assign advance = held_valid && load_ready;

    lpcd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .held_valid (held_valid),
        .take       (advance),
        .held_byte  (held_byte)
    );

    lpcd_parse #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .rx_byte (held_byte),
        .result  (parse_result)
    );

    lpcd_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_valid  (held_valid),
        .load_ready  (load_ready),
        .load_result (parse_result),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (out_result)
    );

    assign m_axis_tdata = out_result.data_byte;
    assign m_axis_tuser = {out_result.length_overflow, out_result.message_end,
                           out_result.data_valid};

endmodule

>>> verif/tb_length_prefixed_chunk_deframer_top.sv
// Self-checking testbench for length_prefixed_chunk_deframer_top.
// Depends on lpcd_pkg and the RTL; it predicts every result beat itself and checks it in order.
module tb_length_prefixed_chunk_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF      = 10;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [15:0] LEN_MAX       = 16'hFFFF;
    localparam int          SETTLE_CYCLES = 8;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;   // [7:0] data_byte
    logic [2:0] m_axis_tuser;   // [0] data_valid, [1] message_end, [2] length_overflow

    // Idle percentages for each side; the test sequence changes them per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Our own copy of the deframer state.
    lpcd_pkg::parse_mode_t dfm_mode;
    logic [15:0]           dfm_len_acc;
    logic                  dfm_digits_off;
    logic [15:0]           dfm_left;

    lpcd_pkg::result_t expected_results[$];
    int                bytes_sent    = 0;
    int                mismatches    = 0;
    int                stall_cycles  = 0;

    length_prefixed_chunk_deframer_top #(
        .LEN_WIDTH(16)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    // Advance the deframer state by one received byte and return the beat it must produce.
    function automatic lpcd_pkg::result_t deframe_byte(input logic [7:0] b);
        lpcd_pkg::result_t r;
        logic [19:0]       grown;
        r = '0;
        case (dfm_mode)
            lpcd_pkg::MODE_PAYLOAD: begin
                r.data_byte  = b;
                r.data_valid = 1'b1;
                dfm_left     = dfm_left - 16'd1;
                if (dfm_left == 16'd0) begin
                    dfm_mode = lpcd_pkg::MODE_IDLE;
                end
            end
            lpcd_pkg::MODE_LENGTH: begin
                if (b == lpcd_pkg::CH_CLOSE) begin
                    dfm_left = dfm_len_acc;
                    if (dfm_len_acc != 16'd0) begin
                        dfm_mode = lpcd_pkg::MODE_PAYLOAD;
                    end else begin
                        dfm_mode = lpcd_pkg::MODE_IDLE;
                    end
                    dfm_len_acc    = 16'd0;
                    dfm_digits_off = 1'b0;
                end else if (b >= lpcd_pkg::CH_ZERO && b <= lpcd_pkg::CH_NINE
                             && !dfm_digits_off) begin
                    grown = {4'd0, dfm_len_acc} * 20'd10 + {12'd0, b - lpcd_pkg::CH_ZERO};
                    if (grown > {4'd0, LEN_MAX}) begin
                        dfm_len_acc       = LEN_MAX;
                        r.length_overflow = 1'b1;
                    end else begin
                        dfm_len_acc = grown[15:0];
                    end
                end else begin
                    // Any non-digit, signs and whitespace included, ends digit collection.
                    dfm_digits_off = 1'b1;
                end
            end
            default: begin
                dfm_mode = lpcd_pkg::MODE_IDLE;
                if (b == lpcd_pkg::CH_END) begin
                    r.message_end = 1'b1;
                end else if (b == lpcd_pkg::CH_OPEN) begin
                    dfm_mode       = lpcd_pkg::MODE_LENGTH;
                    dfm_len_acc    = 16'd0;
                    dfm_digits_off = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    // Payload bytes lean toward the framing characters so they show up inside chunks.
    function automatic logic [7:0] pick_payload_byte();
        case ($urandom_range(0, 7))
            0:       return lpcd_pkg::CH_END;
            1:       return lpcd_pkg::CH_OPEN;
            2:       return lpcd_pkg::CH_CLOSE;
            3:       return lpcd_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Noise between messages never opens a chunk.
    function automatic logic [7:0] pick_noise_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == lpcd_pkg::CH_OPEN);
        return b;
    endfunction

    // Sends one byte. Starts and ends at a falling edge; records the prediction on acceptance.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        expected_results.push_back(deframe_byte(b));
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_byte(text[i]);
        end
    endtask

    // Feeds payload for as long as the prediction says a chunk is open.
    task automatic send_open_payload();
        while (dfm_mode == lpcd_pkg::MODE_PAYLOAD) begin
            send_byte(pick_payload_byte());
        end
    endtask

    // Sender holds off until every predicted beat has been taken by the receiver.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // A well-formed chunk: '(' optional leading zeros, decimal length (may be empty for zero), ')', payload.
    task automatic send_chunk(input int len);
        logic [7:0] digits[$];
        int         v;
        send_byte(lpcd_pkg::CH_OPEN);
        if (len != 0 || $urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(1, 3) : 0) begin
                send_byte(lpcd_pkg::CH_ZERO);
            end
            v = len;
            do begin
                digits.push_front(lpcd_pkg::CH_ZERO + 8'(v % 10));
                v = v / 10;
            end while (v != 0);
            foreach (digits[i]) send_byte(digits[i]);
        end
        send_byte(lpcd_pkg::CH_CLOSE);
        send_open_payload();
    endtask

    // A chunk whose length field carries junk after at most two digits.
    task automatic send_broken_chunk();
        logic [7:0] b;
        send_byte(lpcd_pkg::CH_OPEN);
        repeat ($urandom_range(0, 2)) send_byte(lpcd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        do begin
            b = 8'($urandom_range(0, 255));
        end while ((b >= lpcd_pkg::CH_ZERO && b <= lpcd_pkg::CH_NINE)
                   || b == lpcd_pkg::CH_CLOSE);
        send_byte(b);
        repeat ($urandom_range(0, 3)) begin
            do begin
                b = pick_payload_byte();
            end while (b == lpcd_pkg::CH_CLOSE);
            send_byte(b);
        end
        send_byte(lpcd_pkg::CH_CLOSE);
        send_open_payload();
    endtask

    // Bytes outside any chunk: message end, dropped bytes and the value extremes.
    task automatic test_idle_bytes();
        send_byte(lpcd_pkg::CH_END);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(lpcd_pkg::CH_NINE);
        send_byte(lpcd_pkg::CH_CLOSE);
    endtask

    // Empty and zero lengths, framing characters inside payload, digits after a
    // non-digit, a sign in the length and a second '(' while parsing a length.
    task automatic test_chunk_forms();
        send_text("()");
        send_text("(0)");
        send_text("(03)$()");
        send_text("(1x9)");
        send_open_payload();
        send_text("(+1)");
        send_text("((1)");
        send_byte(lpcd_pkg::CH_END);
    endtask

    // 65535 is the largest length that fits; the next two digits saturate and flag,
    // and a digit after a sign is ignored without a flag. This runs last and leaves
    // the length open, since closing it would commit a full 65535-byte payload.
    task automatic test_length_saturation();
        send_text("(65535");
        send_byte(lpcd_pkg::CH_NINE);
        send_byte(lpcd_pkg::CH_ZERO);
        send_text("-7");
    endtask

    // Mostly well-formed messages with random content, some broken chunks and noise.
    task automatic test_random_stream(input int n_items);
        int target;
        int pick;
        target = bytes_sent + n_items;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_chunk($urandom_range(9, 300));
                    end else begin
                        send_chunk($urandom_range(0, 8));
                    end
                end
                send_byte(lpcd_pkg::CH_END);
            end else if (pick < 90) begin
                send_broken_chunk();
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(pick_noise_byte());
            end
        end
    endtask

    // Receiver: ready changes at the falling edge only.
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result checker: each accepted beat against the oldest prediction.
    always @(posedge aclk) begin
        lpcd_pkg::result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected beat: tdata=%02h tuser=%03b", m_axis_tdata,
                             m_axis_tuser);
                end
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata !== want.data_byte || m_axis_tuser[0] !== want.data_valid
                    || m_axis_tuser[1] !== want.message_end
                    || m_axis_tuser[2] !== want.length_overflow) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: data_byte %02h/%02h valid %b/%b end %b/%b ovf %b/%b",
                                 want.data_byte, m_axis_tdata, want.data_valid,
                                 m_axis_tuser[0], want.message_end, m_axis_tuser[1],
                                 want.length_overflow, m_axis_tuser[2]);
                    end
                end
            end
        end
    end

    // Watchdog: too many cycles without a beat on either side ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        dfm_mode       = lpcd_pkg::MODE_IDLE;
        dfm_len_acc    = 16'd0;
        dfm_digits_off = 1'b0;
        dfm_left       = 16'd0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 36;
        recv_idle_pct = 48;
        test_idle_bytes();
        test_chunk_forms();
        test_random_stream(420);
        wait_drained();

        send_idle_pct = 48;
        recv_idle_pct = 36;
        test_random_stream(420);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(420);
        test_length_saturation();
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (expected_results.size() != 0) begin
            mismatches++;
            $display("%0d predicted beats never arrived", expected_results.size());
        end
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
